FILE: hdl/huffman_code_bit_packer_core_defines.svh
`ifndef HUFFMAN_CODE_BIT_PACKER_CORE_DEFINES_SVH
`define HUFFMAN_CODE_BIT_PACKER_CORE_DEFINES_SVH

// check a condition in the same cycle as its trigger
`define HCBP_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// check a condition in the cycle after its trigger
`define HCBP_ASSERT_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/hcbp_pkg.sv
package hcbp_pkg;

  localparam int SYMBOL_COUNT_DEF = 256;
  localparam int MAX_CODE_LEN_DEF = 32;

  localparam int OP_W    = 2;
  localparam int SYM_W   = 8;
  localparam int WORD_W  = 32;
  localparam int LEN_W   = 6;
  localparam int BYTE_W  = 8;
  localparam int NBITS_W = 4;
  localparam int TOTAL_W = 32;
  localparam int ACC_W   = WORD_W + BYTE_W;

  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_ENCODE = 2'd1;
  localparam logic [OP_W-1:0] OP_FLUSH  = 2'd2;

  typedef struct packed {
    logic              flush;
    logic [WORD_W-1:0] aligned;
    logic [LEN_W-1:0]  len;
  } sym_t;

endpackage

FILE: hdl/hcbp_if.sv
interface hcbp_in_if;
  logic                       valid;
  logic                       ready;
  logic [hcbp_pkg::OP_W-1:0]   op;
  logic [hcbp_pkg::SYM_W-1:0]  symbol;
  logic [hcbp_pkg::WORD_W-1:0] code_word;
  logic [hcbp_pkg::LEN_W-1:0]  code_length;

  modport source(output valid, op, symbol, code_word, code_length, input ready);
  modport sink(input valid, op, symbol, code_word, code_length, output ready);
endinterface

interface hcbp_out_if;
  logic                        valid;
  logic                        ready;
  logic [hcbp_pkg::BYTE_W-1:0]  out_byte;
  logic [hcbp_pkg::NBITS_W-1:0] valid_bits;
  logic [hcbp_pkg::TOTAL_W-1:0] bit_total;
  logic                        run_last;

  modport source(output valid, out_byte, valid_bits, bit_total, run_last, input ready);
  modport sink(input valid, out_byte, valid_bits, bit_total, run_last, output ready);
endinterface

FILE: hdl/hcbp_table.sv
`include "huffman_code_bit_packer_core_defines.svh"

module hcbp_table #(
  parameter int SYMBOL_COUNT = hcbp_pkg::SYMBOL_COUNT_DEF,
  parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF
) (
  input  logic            clk,
  input  logic            rst,
  hcbp_in_if.sink         ingress,
  output logic            s2_v,
  output hcbp_pkg::sym_t  s2,
  input  logic            s2_take
);

  localparam int IDX_W = $clog2(SYMBOL_COUNT);
  localparam int CAP   = (MAX_CODE_LEN < hcbp_pkg::WORD_W) ? MAX_CODE_LEN : hcbp_pkg::WORD_W;
  localparam logic [hcbp_pkg::LEN_W-1:0] CAP_LEN  = hcbp_pkg::LEN_W'(CAP);
  localparam logic [hcbp_pkg::LEN_W-1:0] WORD_LEN = hcbp_pkg::LEN_W'(hcbp_pkg::WORD_W);

  logic [hcbp_pkg::WORD_W-1:0] code_mem [SYMBOL_COUNT];
  logic [hcbp_pkg::LEN_W-1:0]  len_mem  [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0]     written;

  logic                        accept;
  logic                        in_range;
  logic [IDX_W-1:0]            idx;
  logic [hcbp_pkg::LEN_W-1:0]  len_sat;
  logic                        wr;
  logic                        rd;

  logic                        s1_v;
  logic                        s1_flush;
  logic [hcbp_pkg::WORD_W-1:0] rd_code;
  logic [hcbp_pkg::LEN_W-1:0]  rd_len;
  logic                        rd_written;
  logic [hcbp_pkg::LEN_W-1:0]  s1_len;
  logic [hcbp_pkg::WORD_W-1:0] s1_aligned;
  logic                        s1_ready;
  logic                        s2_ready;

  assign s2_ready      = !s2_v || s2_take;
  assign s1_ready      = !s1_v || s2_ready;
  assign ingress.ready = s1_ready;
  assign accept        = ingress.valid && ingress.ready;

  assign in_range = (int'(ingress.symbol) < SYMBOL_COUNT);
  assign idx      = ingress.symbol[IDX_W-1:0];
  assign len_sat  = (ingress.code_length > CAP_LEN) ? CAP_LEN : ingress.code_length;

  assign wr = accept && (ingress.op == hcbp_pkg::OP_LOAD) && in_range;
  assign rd = accept && (((ingress.op == hcbp_pkg::OP_ENCODE) && in_range) ||
                         (ingress.op == hcbp_pkg::OP_FLUSH));

  always_ff @(posedge clk) begin
    if (wr) begin
      code_mem[idx] <= ingress.code_word;
      len_mem[idx]  <= len_sat;
    end
    if (rd) begin
      rd_code    <= code_mem[idx];
      rd_len     <= len_mem[idx];
      rd_written <= written[idx];
      s1_flush   <= (ingress.op == hcbp_pkg::OP_FLUSH);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr) begin
      written[idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (s1_ready) begin
      s1_v <= rd;
    end
  end

  assign s1_len     = rd_written ? rd_len : '0;
  assign s1_aligned = (s1_len == '0) ? '0 : (rd_code << (WORD_LEN - s1_len));

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (s2_ready) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_v) begin
      s2.flush   <= s1_flush;
      s2.aligned <= s1_aligned;
      s2.len     <= s1_flush ? '0 : s1_len;
    end
  end

  `HCBP_ASSERT_IMP(a_len_cap, clk, rst, s2_v && !s2.flush, s2.len <= CAP_LEN, "code length above cap")
  `HCBP_ASSERT_NXT(a_s1_hold, clk, rst, s1_v && !s2_ready, s1_v, "stalled request lost")

endmodule

FILE: hdl/hcbp_pack.sv
`include "huffman_code_bit_packer_core_defines.svh"

module hcbp_pack (
  input  logic            clk,
  input  logic            rst,
  input  logic            s2_v,
  input  hcbp_pkg::sym_t  s2,
  output logic            s2_take,
  hcbp_out_if.source      egress
);

  localparam int BW = hcbp_pkg::BYTE_W;
  localparam int AW = hcbp_pkg::ACC_W;
  localparam logic [hcbp_pkg::LEN_W-1:0]  BYTE_LEN = hcbp_pkg::LEN_W'(BW);
  localparam logic [hcbp_pkg::LEN_W-1:0]  TWO_BYTE = hcbp_pkg::LEN_W'(2 * BW);
  localparam logic [hcbp_pkg::NBITS_W-1:0] FULL_BITS = hcbp_pkg::NBITS_W'(BW);

  logic [AW-1:0]                acc;
  logic [AW-1:0]                acc_next;
  logic [hcbp_pkg::LEN_W-1:0]   acc_n;
  logic [hcbp_pkg::LEN_W-1:0]   acc_n_next;
  logic [hcbp_pkg::TOTAL_W-1:0] base;
  logic [hcbp_pkg::TOTAL_W-1:0] base_next;

  logic                         out_v;
  logic [BW-1:0]                out_byte;
  logic [hcbp_pkg::NBITS_W-1:0] out_bits;
  logic [hcbp_pkg::TOTAL_W-1:0] out_total;
  logic                         out_last;

  logic                         slot_free;
  logic                         emit;
  logic                         enc_take;
  logic                         fl_take;
  logic [AW-1:0]                acc_sh;
  logic [hcbp_pkg::LEN_W-1:0]   n_sh;
  logic [AW-1:0]                ins;
  logic [hcbp_pkg::TOTAL_W:0]   sum_byte;
  logic [hcbp_pkg::TOTAL_W:0]   sum_fl;
  logic [hcbp_pkg::TOTAL_W-1:0] sat_byte;
  logic [hcbp_pkg::TOTAL_W-1:0] sat_fl;

  assign slot_free = !out_v || egress.ready;
  assign emit      = (acc_n >= BYTE_LEN) && slot_free;
  assign acc_sh    = emit ? (acc << BW) : acc;
  assign n_sh      = emit ? (acc_n - BYTE_LEN) : acc_n;

  assign enc_take = s2_v && !s2.flush && (n_sh < BYTE_LEN);
  assign fl_take  = s2_v && s2.flush && !emit && (acc_n < BYTE_LEN) && slot_free;
  assign s2_take  = enc_take || fl_take;

  assign ins = {s2.aligned, {BW{1'b0}}} >> n_sh[2:0];

  assign sum_byte = {1'b0, base} + (hcbp_pkg::TOTAL_W+1)'(BW);
  assign sum_fl   = {1'b0, base} + (hcbp_pkg::TOTAL_W+1)'(acc_n);
  assign sat_byte = sum_byte[hcbp_pkg::TOTAL_W] ? '1 : sum_byte[hcbp_pkg::TOTAL_W-1:0];
  assign sat_fl   = sum_fl[hcbp_pkg::TOTAL_W] ? '1 : sum_fl[hcbp_pkg::TOTAL_W-1:0];

  always_comb begin
    acc_next   = acc_sh;
    acc_n_next = n_sh;
    base_next  = emit ? sat_byte : base;
    if (enc_take) begin
      acc_next   = acc_sh | ins;
      acc_n_next = n_sh + s2.len;
    end
    if (fl_take) begin
      acc_next   = '0;
      acc_n_next = '0;
      base_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc   <= '0;
      acc_n <= '0;
      base  <= '0;
      out_v <= 1'b0;
    end else begin
      acc   <= acc_next;
      acc_n <= acc_n_next;
      base  <= base_next;
      if (slot_free) begin
        out_v <= emit || fl_take;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte  <= acc[AW-1 -: BW];
      out_bits  <= FULL_BITS;
      out_total <= sat_byte;
      out_last  <= (acc_n < TWO_BYTE);
    end else if (fl_take) begin
      out_byte  <= acc[AW-1 -: BW];
      out_bits  <= acc_n[hcbp_pkg::NBITS_W-1:0];
      out_total <= sat_fl;
      out_last  <= 1'b1;
    end
  end

  assign egress.valid      = out_v;
  assign egress.out_byte   = out_byte;
  assign egress.valid_bits = out_bits;
  assign egress.bit_total  = out_total;
  assign egress.run_last   = out_last;

  `HCBP_ASSERT_IMP(a_take_room, clk, rst, s2_take, acc_n < TWO_BYTE, "request taken over full bytes")
  `HCBP_ASSERT_NXT(a_flush_clr, clk, rst, fl_take, (acc_n == '0) && (base == '0) && out_v, "flush not cleared")
  `HCBP_ASSERT_IMP(a_acc_range, clk, rst, 1'b1, acc_n < hcbp_pkg::LEN_W'(AW), "bit count overrun")

endmodule

FILE: hdl/huffman_code_bit_packer_core.sv
// channel  | dir | payload                                        | handshake
// ingress  | in  | op, symbol, code_word, code_length             | valid/ready
// egress   | out | out_byte, valid_bits, bit_total, run_last      | valid/ready
//
// Load and dropped requests go no further than ingress; encode and flush pass a
// registered table read and an align stage, then the packer emits their output
// bytes one by one, each held in its output register until egress takes it.
// Sustained rate is set by the single-byte output register of the packer.
// rst clears the table entry valid flags and packer state.
// egress stalls back up through the packer and table stages to ingress.ready.
module huffman_code_bit_packer_core #(
  parameter int SYMBOL_COUNT = hcbp_pkg::SYMBOL_COUNT_DEF,
  parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  hcbp_in_if.sink     ingress,
  hcbp_out_if.source  egress
);

  logic           s2_v;
  hcbp_pkg::sym_t s2;
  logic           s2_take;

  hcbp_table #(
    .SYMBOL_COUNT(SYMBOL_COUNT),
    .MAX_CODE_LEN(MAX_CODE_LEN)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .ingress (ingress),
    .s2_v    (s2_v),
    .s2      (s2),
    .s2_take (s2_take)
  );

  hcbp_pack u_pack (
    .clk     (clk),
    .rst     (rst),
    .s2_v    (s2_v),
    .s2      (s2),
    .s2_take (s2_take),
    .egress  (egress)
  );

endmodule

FILE: tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hcbp_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int LEN_CAP = (MAX_CODE_LEN_DEF < WORD_W) ? MAX_CODE_LEN_DEF : WORD_W;
  localparam int RANDOM_REQS = 405;
  localparam int QUIET_TAIL = 60;
  localparam int IDLE_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 20;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [SYM_W-1:0]  symbol;
    logic [WORD_W-1:0] code_word;
    logic [LEN_W-1:0]  code_length;
    bit                hold;
  } request_t;

  typedef struct {
    logic [BYTE_W-1:0]  out_byte;
    logic [NBITS_W-1:0] valid_bits;
    logic [TOTAL_W-1:0] bit_total;
    logic               run_last;
  } packed_byte_t;

  logic clk;
  logic rst = 1'b1;

  hcbp_in_if  ingress();
  hcbp_out_if egress();

  huffman_code_bit_packer_core DUT (
    .clk(clk),
    .rst(rst),
    .ingress(ingress),
    .egress(egress)
  );

  request_t     pending[$];
  packed_byte_t expected_bytes[$];

  bit [WORD_W-1:0]  code_tbl[SYMBOL_COUNT_DEF];
  bit [LEN_W-1:0]   len_tbl[SYMBOL_COUNT_DEF];
  bit [BYTE_W-1:0]  acc_byte;
  int               acc_fill;
  bit [TOTAL_W-1:0] bits_emitted;

  bit               gen_loaded[SYMBOL_COUNT_DEF];
  bit [SYM_W-1:0]   loaded_syms[$];

  int fail_count;
  int idle_cycles;
  int gap_left;
  int stall_left;
  bit req_taken;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    fail_count++;
  endtask

  function automatic logic [LEN_W-1:0] rand_len();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r < 3) return LEN_W'($urandom_range(13, 63));
    return LEN_W'($urandom_range(1, 12));
  endfunction

  task automatic add_req(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym,
                         input logic [WORD_W-1:0] word, input logic [LEN_W-1:0] len,
                         input bit hold);
    request_t r;
    r = '{op, sym, word, len, hold};
    pending.push_back(r);
    if (op == OP_LOAD && !gen_loaded[sym]) begin
      gen_loaded[sym] = 1'b1;
      loaded_syms.push_back(sym);
    end
  endtask

  function automatic void predict_packing(request_t r);
    packed_byte_t held;
    bit have;
    int n;
    case (r.op)
      OP_LOAD: begin
        if (r.symbol < SYMBOL_COUNT_DEF) begin
          code_tbl[r.symbol] = r.code_word;
          len_tbl[r.symbol] = (r.code_length > LEN_CAP) ? LEN_W'(LEN_CAP) : r.code_length;
        end
      end
      OP_ENCODE: begin
        have = 1'b0;
        if (r.symbol < SYMBOL_COUNT_DEF) begin
          n = int'(len_tbl[r.symbol]);
          for (int i = n; i > 0; i--) begin
            acc_byte[7 - acc_fill] = code_tbl[r.symbol][i - 1];
            acc_fill++;
            if (bits_emitted != '1) bits_emitted++;
            if (acc_fill == 8) begin
              if (have) expected_bytes.push_back(held);
              held = '{acc_byte, NBITS_W'(8), bits_emitted, 1'b0};
              have = 1'b1;
              acc_byte = '0;
              acc_fill = 0;
            end
          end
        end
        if (have) begin
          held.run_last = 1'b1;
          expected_bytes.push_back(held);
        end
      end
      OP_FLUSH: begin
        held = '{acc_byte, NBITS_W'(acc_fill), bits_emitted, 1'b1};
        expected_bytes.push_back(held);
        acc_byte = '0;
        acc_fill = 0;
        bits_emitted = '0;
      end
      default: ;
    endcase
  endfunction

  // request driver
  always @(negedge clk) begin
    request_t cur;
    if (!rst && (!ingress.valid || req_taken)) begin
      req_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        ingress.valid <= 1'b0;
      end else if (pending.size() == 0 || (pending[0].hold && expected_bytes.size() != 0)) begin
        ingress.valid <= 1'b0;
      end else if (pending.size() >= QUIET_TAIL && $urandom_range(0, 9) == 0) begin
        gap_left = $urandom_range(0, 8);
        ingress.valid <= 1'b0;
      end else begin
        cur = pending.pop_front();
        ingress.op <= cur.op;
        ingress.symbol <= cur.symbol;
        ingress.code_word <= cur.code_word;
        ingress.code_length <= cur.code_length;
        ingress.valid <= 1'b1;
      end
    end
  end

  // result backpressure
  always @(negedge clk) begin
    if (!rst) begin
      if (stall_left > 0) begin
        stall_left = stall_left - 1;
        egress.ready <= 1'b0;
      end else if (pending.size() >= QUIET_TAIL && $urandom_range(0, 11) == 0) begin
        stall_left = $urandom_range(0, 8);
        egress.ready <= 1'b0;
      end else begin
        egress.ready <= 1'b1;
      end
    end
  end

  // monitor, checker and watchdog
  always @(posedge clk) begin
    request_t seen;
    packed_byte_t want;
    bit fired;
    if (!rst) begin
      fired = 1'b0;
      if (ingress.valid && ingress.ready) begin
        seen = '{ingress.op, ingress.symbol, ingress.code_word, ingress.code_length, 1'b0};
        predict_packing(seen);
        req_taken = 1'b1;
        fired = 1'b1;
      end
      if (egress.valid && egress.ready) begin
        fired = 1'b1;
        if (expected_bytes.size() == 0) begin
          report_mismatch($sformatf("unexpected result byte 0x%0h bits %0d total %0d",
                                    egress.out_byte, egress.valid_bits, egress.bit_total));
        end else begin
          want = expected_bytes.pop_front();
          if (egress.out_byte !== want.out_byte)
            report_mismatch($sformatf("out_byte 0x%0h, expected 0x%0h",
                                      egress.out_byte, want.out_byte));
          if (egress.valid_bits !== want.valid_bits)
            report_mismatch($sformatf("valid_bits %0d, expected %0d",
                                      egress.valid_bits, want.valid_bits));
          if (egress.bit_total !== want.bit_total)
            report_mismatch($sformatf("bit_total %0d, expected %0d",
                                      egress.bit_total, want.bit_total));
          if (egress.run_last !== want.run_last)
            report_mismatch($sformatf("run_last %0b, expected %0b",
                                      egress.run_last, want.run_last));
        end
      end
      idle_cycles = fired ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    int n;
    int pick;
    logic [SYM_W-1:0] s;

    ingress.valid = 1'b0;
    ingress.op = OP_LOAD;
    ingress.symbol = '0;
    ingress.code_word = '0;
    ingress.code_length = '0;
    egress.ready = 1'b1;

    add_req(OP_FLUSH, 8'h00, 32'h0, 6'd0, 1'b0);
    add_req(OP_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'h3F, 1'b0);
    add_req(OP_LOAD, 8'h00, 32'hFFFF_FFFF, 6'd32, 1'b0);
    // overlong lengths saturate
    add_req(OP_LOAD, 8'hFF, 32'h0000_0000, 6'd63, 1'b0);
    add_req(OP_LOAD, 8'hA5, 32'h8000_0001, 6'd33, 1'b0);
    // absent code
    add_req(OP_LOAD, 8'h5A, 32'h0000_0003, 6'd0, 1'b0);
    add_req(OP_LOAD, 8'h01, 32'h0000_0016, 6'd5, 1'b0);
    add_req(OP_ENCODE, 8'h00, 32'h0, 6'd0, 1'b0);
    add_req(OP_ENCODE, 8'h5A, 32'h0, 6'd0, 1'b0);
    add_req(OP_ENCODE, 8'h01, 32'h0, 6'd0, 1'b0);
    add_req(OP_UNUSED, 8'h01, 32'h1234_5678, 6'd7, 1'b0);
    add_req(OP_ENCODE, 8'hFF, 32'h0, 6'd0, 1'b0);
    add_req(OP_ENCODE, 8'hA5, 32'h0, 6'd0, 1'b0);
    add_req(OP_FLUSH, 8'hFF, 32'hFFFF_FFFF, 6'h3F, 1'b0);
    add_req(OP_FLUSH, 8'h00, 32'h0, 6'd0, 1'b0);
    add_req(OP_LOAD, 8'h02, 32'h0000_00AB, 6'd8, 1'b0);
    add_req(OP_ENCODE, 8'h02, 32'h0, 6'd0, 1'b0);
    add_req(OP_ENCODE, 8'h02, 32'h0, 6'd0, 1'b0);
    add_req(OP_LOAD, 8'h03, 32'hFFFF_FF55, 6'd7, 1'b0);
    add_req(OP_ENCODE, 8'h03, 32'h0, 6'd0, 1'b0);
    add_req(OP_ENCODE, 8'h03, 32'h0, 6'd0, 1'b0);
    add_req(OP_FLUSH, 8'h00, 32'h0, 6'd0, 1'b1);

    n = 0;
    repeat (24) begin
      add_req(OP_LOAD, SYM_W'($urandom_range(0, 255)), $urandom(), rand_len(), 1'b0);
      n++;
    end
    while (n < RANDOM_REQS) begin
      if (n == RANDOM_REQS / 2) begin
        add_req(OP_FLUSH, SYM_W'($urandom_range(0, 255)), $urandom(), rand_len(), 1'b1);
        n++;
      end
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        add_req(OP_LOAD, SYM_W'($urandom_range(0, 255)), $urandom(), rand_len(), 1'b0);
        n++;
      end else if (pick < 88) begin
        s = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
        add_req(OP_ENCODE, s, $urandom(), LEN_W'($urandom_range(0, 63)), 1'b0);
        n++;
      end else if (pick < 95) begin
        add_req(OP_FLUSH, SYM_W'($urandom_range(0, 255)), $urandom(), rand_len(), 1'b0);
        n++;
      end else begin
        add_req(OP_UNUSED, SYM_W'($urandom_range(0, 255)), $urandom(),
                LEN_W'($urandom_range(0, 63)), 1'b0);
      end
    end
    add_req(OP_FLUSH, 8'h00, 32'h0, 6'd0, 1'b0);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending.size() != 0 || ingress.valid) @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
